// File: sv/cird_pkg.sv
`default_nettype none

package cird_pkg;

  // Access kinds on the processor side.
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // I/O page offsets.
  localparam logic [7:0] OFF_ATA_LO      = 8'h20;
  localparam logic [7:0] OFF_ATA_HI      = 8'h2f;
  localparam logic [7:0] OFF_PAIR_LO     = 8'h28;
  localparam logic [7:0] OFF_PAIR_HI     = 8'h29;
  localparam logic [7:0] OFF_DATA_LO     = 8'h30;
  localparam logic [7:0] OFF_DATA_HI     = 8'h31;
  localparam logic [7:0] OFF_STATUS      = 8'h32;
  localparam logic [7:0] OFF_BANK_OLD_HI = 8'h35;
  localparam logic [7:0] OFF_ID          = 8'h5d;
  localparam logic [7:0] OFF_STATUS2     = 8'h5e;
  localparam logic [7:0] OFF_RTC         = 8'h5f;
  localparam logic [7:0] OFF_ROM_LO      = 8'h60;
  localparam logic [7:0] OFF_BANK_NEW_HI = 8'h67;
  localparam logic [7:0] OFF_KILL        = 8'hfb;
  localparam logic [7:0] OFF_MODE_LO     = 8'hfc;

  // Fixed values seen on the bus.
  localparam logic [16:0] ROM_WINDOW_BASE = 17'h01e00;
  localparam logic [7:0]  ID_BYTE         = 8'hff;
  localparam logic [7:0]  STATUS2_MASK    = 8'hc0;
  localparam logic [7:0]  STATUS_OLD_TAG  = 8'h10;
  localparam logic [7:0]  STATUS_NEW_TAG  = 8'h20;

  // Kill register bits.
  localparam int unsigned KILL_BIT  = 0;
  localparam int unsigned CLOCK_BIT = 1;

  typedef enum logic [1:0] {
    ATA_NONE  = 2'd0,
    ATA_READ  = 2'd1,
    ATA_WRITE = 2'd2
  } ata_action_e;

  typedef enum logic [1:0] {
    RTC_NONE      = 2'd0,
    RTC_READ_BIT  = 2'd1,
    RTC_WRITE_BIT = 2'd2,
    RTC_CE_DROP   = 2'd3
  } rtc_action_e;

  typedef enum logic [1:0] {
    MODE_8K   = 2'd0,
    MODE_16K  = 2'd1,
    MODE_STD  = 2'd2,
    MODE_OPEN = 2'd3
  } map_mode_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  offset;
    logic [7:0]  write_data;
    logic [15:0] ata_read_data;
    logic        rtc_data_in;
    logic [7:0]  open_bus_data;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        bus_claimed;
    logic        rom_read;
    logic [16:0] rom_address;
    ata_action_e ata_action;
    logic [3:0]  ata_register;
    logic [15:0] ata_write_data;
    logic        drive_pair;
    rtc_action_e rtc_action;
    logic        map_update;
    map_mode_e   map_mode;
    logic [2:0]  map_bank;
  } out_beat_t;

endpackage

`default_nettype wire

// File: sv/cartridge_io_register_decoder.sv
// Cartridge I/O page register decoder.
//
// The input channel (in_valid_i / in_ready_o / in_data_i) carries one
// processor bus access per beat: kind, page offset, write byte, the drives'
// read value, the clock chip data line and the floating bus value. The
// output channel (out_valid_o / out_ready_i / out_data_o) returns one result
// beat per access with read data, bus claim, ROM window address, drive and
// clock chip actions and the memory map state after the access.
// An access accepted into the input register is decoded there, and its result
// enters the output register when that register is free. One access is taken
// every cycle while the receiver keeps up; the rate is set by the single
// decode stage between the two registers.
// When the receiver stalls, the result is held and the input register still
// takes one more beat; further beats wait until the output register drains.
// cfg_we_i writes the layout select (cfg_wdata_i); the user must write it only while the block is idle (not enforced).
// Reset clears the kill register, bank, memory mode, pair select and both
// data latches and selects the old register layout.

`default_nettype none

module cartridge_io_register_decoder (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire cird_pkg::in_beat_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output cird_pkg::out_beat_t      out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i
);

  // Pipeline control and payload registers.
  logic                s1_valid_q;
  cird_pkg::in_beat_t  s1_beat_q;
  logic                out_valid_q;
  cird_pkg::out_beat_t out_beat_q, out_beat_d;
  logic                out_free;
  logic                s1_fire;

  // Architectural state.
  logic                v4_q;
  logic [7:0]          kill_q, kill_d;
  logic [2:0]          bank_q, bank_d;
  cird_pkg::map_mode_e mode_q, mode_d;
  logic                pair_q, pair_d;
  logic [15:0]         rlatch_q, rlatch_d;
  logic [15:0]         wlatch_q, wlatch_d;

  // Decode helpers.
  logic [7:0]          off;
  logic                v4;
  logic                killed;
  logic                in_ata;
  logic [15:0]         wlatch_lo;
  logic [7:0]          status_byte;

  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_fire     = s1_valid_q && out_free;
  assign in_ready_o  = !s1_valid_q || out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_beat_q;

  // Handshake registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_beat_q <= in_data_i;
    end
    if (s1_fire) begin
      out_beat_q <= out_beat_d;
    end
  end

  // State registers: layout select on a config write, the rest as an access moves into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q     <= 1'b0;
      kill_q   <= '0;
      bank_q   <= '0;
      mode_q   <= cird_pkg::MODE_8K;
      pair_q   <= 1'b0;
      rlatch_q <= '0;
      wlatch_q <= '0;
    end else begin
      if (cfg_we_i) begin
        v4_q <= cfg_wdata_i;
      end
      if (s1_fire) begin
        kill_q   <= kill_d;
        bank_q   <= bank_d;
        mode_q   <= mode_d;
        pair_q   <= pair_d;
        rlatch_q <= rlatch_d;
        wlatch_q <= wlatch_d;
      end
    end
  end

  assign off       = s1_beat_q.offset;
  assign v4        = v4_q;
  assign killed    = kill_q[cird_pkg::KILL_BIT] && (off >= cird_pkg::OFF_RTC);
  assign in_ata    = (off >= cird_pkg::OFF_ATA_LO) && (off <= cird_pkg::OFF_ATA_HI);
  assign wlatch_lo = {wlatch_q[15:8], s1_beat_q.write_data};

  // Status byte: layout tag, bank and memory mode lines.
  assign status_byte = (v4 ? cird_pkg::STATUS_NEW_TAG : cird_pkg::STATUS_OLD_TAG)
                     | {3'b000, bank_q, 2'b00}
                     | {6'b000000, ~mode_q[0], mode_q[1]};

  // Access decode.
  always_comb begin
    kill_d   = kill_q;
    bank_d   = bank_q;
    mode_d   = mode_q;
    pair_d   = pair_q;
    rlatch_d = rlatch_q;
    wlatch_d = wlatch_q;

    out_beat_d                = '0;
    out_beat_d.ata_action     = cird_pkg::ATA_NONE;
    out_beat_d.rtc_action     = cird_pkg::RTC_NONE;
    out_beat_d.map_mode       = cird_pkg::MODE_8K;

    if (s1_beat_q.kind == cird_pkg::KIND_READ) begin
      // Read side: default answer is open bus, unclaimed.
      out_beat_d.read_data = s1_beat_q.open_bus_data;
      if (killed) begin
        out_beat_d.read_data = s1_beat_q.open_bus_data;
      end else if (off >= cird_pkg::OFF_ROM_LO) begin
        out_beat_d.read_data   = '0;
        out_beat_d.bus_claimed = 1'b1;
        out_beat_d.rom_read    = 1'b1;
        out_beat_d.rom_address = {9'b0, off} | cird_pkg::ROM_WINDOW_BASE
                               | {bank_q, 14'b0};
      end else if (in_ata) begin
        rlatch_d                = s1_beat_q.ata_read_data;
        out_beat_d.ata_action   = cird_pkg::ATA_READ;
        out_beat_d.ata_register = off[3:0];
        if (v4) begin
          out_beat_d.read_data   = s1_beat_q.ata_read_data[7:0];
          out_beat_d.bus_claimed = 1'b1;
        end
      end else if (off == cird_pkg::OFF_DATA_LO && !v4) begin
        out_beat_d.read_data   = rlatch_q[7:0];
        out_beat_d.bus_claimed = 1'b1;
      end else if (off == cird_pkg::OFF_DATA_HI) begin
        out_beat_d.read_data   = rlatch_q[15:8];
        out_beat_d.bus_claimed = 1'b1;
      end else if (off == cird_pkg::OFF_STATUS) begin
        out_beat_d.read_data   = status_byte;
        out_beat_d.bus_claimed = 1'b1;
      end else if (off == cird_pkg::OFF_ID && v4) begin
        out_beat_d.read_data   = cird_pkg::ID_BYTE;
        out_beat_d.bus_claimed = 1'b1;
      end else if (off == cird_pkg::OFF_STATUS2 && v4) begin
        out_beat_d.read_data   = cird_pkg::STATUS2_MASK | s1_beat_q.open_bus_data;
        out_beat_d.bus_claimed = 1'b1;
      end else if (off == cird_pkg::OFF_RTC) begin
        out_beat_d.bus_claimed = 1'b1;
        if (kill_q[cird_pkg::CLOCK_BIT]) begin
          out_beat_d.read_data  = {s1_beat_q.open_bus_data[7:1], s1_beat_q.rtc_data_in};
          out_beat_d.rtc_action = cird_pkg::RTC_READ_BIT;
        end
      end
    end else if (!killed) begin
      // Write side.
      if (in_ata) begin
        if (off == cird_pkg::OFF_PAIR_LO || off == cird_pkg::OFF_PAIR_HI) begin
          pair_d = off[0];
        end
        if (v4) begin
          wlatch_d = wlatch_lo;
        end
        out_beat_d.ata_action     = cird_pkg::ATA_WRITE;
        out_beat_d.ata_register   = off[3:0];
        out_beat_d.ata_write_data = v4 ? wlatch_lo : wlatch_q;
      end else if (off == cird_pkg::OFF_DATA_LO) begin
        if (!v4) begin
          wlatch_d = wlatch_lo;
        end
      end else if (off == cird_pkg::OFF_DATA_HI) begin
        wlatch_d = {s1_beat_q.write_data, wlatch_q[7:0]};
      end else if (off >= cird_pkg::OFF_STATUS && off <= cird_pkg::OFF_BANK_OLD_HI) begin
        // Old layout bank select: offsets map to banks zero to three.
        if (!v4) begin
          bank_d = {1'b0, off[1:0] ^ 2'b10};
        end
        out_beat_d.map_update = 1'b1;
      end else if (off == cird_pkg::OFF_RTC) begin
        if (kill_q[cird_pkg::CLOCK_BIT]) begin
          out_beat_d.rtc_action = cird_pkg::RTC_WRITE_BIT;
        end else begin
          out_beat_d.map_update = 1'b1;
        end
      end else if (off >= cird_pkg::OFF_ROM_LO && off <= cird_pkg::OFF_BANK_NEW_HI) begin
        if (v4) begin
          bank_d = off[2:0];
        end
        out_beat_d.map_update = 1'b1;
      end else if (off == cird_pkg::OFF_KILL) begin
        // Enabling the clock chip drops its chip enable first.
        if (!kill_q[cird_pkg::CLOCK_BIT] && s1_beat_q.write_data[cird_pkg::CLOCK_BIT]) begin
          out_beat_d.rtc_action = cird_pkg::RTC_CE_DROP;
        end
        kill_d = s1_beat_q.write_data;
        if (s1_beat_q.write_data[cird_pkg::KILL_BIT]) begin
          mode_d                = cird_pkg::MODE_STD;
          out_beat_d.map_update = 1'b1;
        end
      end else if (off >= cird_pkg::OFF_MODE_LO) begin
        mode_d                = cird_pkg::map_mode_e'(off[1:0] ^ 2'b01);
        out_beat_d.map_update = 1'b1;
      end
    end

    // State after the access.
    out_beat_d.drive_pair = pair_d;
    out_beat_d.map_mode   = mode_d;
    out_beat_d.map_bank   = bank_d;
  end

`ifndef SYNTHESIS
  // Once the cartridge is killed it stays killed until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    kill_q[cird_pkg::KILL_BIT] |=> kill_q[cird_pkg::KILL_BIT])
    else $error("kill bit cleared without reset");

  // An empty output register never blocks the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty output register");

  // ROM window reads are always claimed and carry no drive access.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_beat_q.rom_read |->
      out_beat_q.bus_claimed && out_beat_q.ata_action == cird_pkg::ATA_NONE)
    else $error("ROM window read decoded inconsistently");

  // No drive access means zero register number and write data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_beat_q.ata_action == cird_pkg::ATA_NONE |->
      out_beat_q.ata_register == '0 && out_beat_q.ata_write_data == '0)
    else $error("drive fields set without a drive access");

  // Kill, bank and write latch change only when an access moves to the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(kill_q) && $stable(bank_q) && $stable(wlatch_q))
    else $error("state changed without an access");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none

module tb;

  // Clock, reset and the signals driven into the decoder.
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  cird_pkg::in_beat_t  in_data = '0;
  logic                out_ready = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_wdata = 1'b0;
  logic                in_ready;
  logic                out_valid;
  cird_pkg::out_beat_t out_data;

  // Stimulus waiting to be offered and results predicted for accepted beats.
  cird_pkg::in_beat_t  pending_accesses[$];
  cird_pkg::out_beat_t predicted_results[$];

  // Shadow copy of the decoder registers used by the predictor.
  logic        layout_v4 = 1'b0;
  logic [7:0]  kill_q = '0;
  logic [2:0]  bank_q = '0;
  logic [1:0]  mode_q = '0;
  logic        pair_q = 1'b0;
  logic [15:0] rd_latch = '0;
  logic [15:0] wr_latch = '0;

  // Flow control and bookkeeping.
  logic in_taken = 1'b0;
  logic hold_off = 1'b0;
  int   idle_pct = 27;
  int   mismatches = 0;
  int   accesses_taken = 0;
  int   results_seen = 0;
  int   writes_taken = 0;
  int   rom_reads = 0;
  int   ata_ops = 0;
  int   rtc_ops = 0;
  int   map_updates = 0;

  cartridge_io_register_decoder i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Decode one bus access against the shadow registers and return its result beat.
  function automatic cird_pkg::out_beat_t decode_access(cird_pkg::in_beat_t a);
    cird_pkg::out_beat_t r;
    logic [7:0]          d;
    logic [1:0]          b;
    logic                killed;
    r = '0;
    killed = kill_q[cird_pkg::KILL_BIT] && (a.offset >= cird_pkg::OFF_RTC);
    if (a.kind == cird_pkg::KIND_READ) begin
      // Anything not claimed below answers with the floating bus value.
      r.read_data = a.open_bus_data;
      if (!killed) begin
        if (a.offset >= cird_pkg::OFF_ROM_LO) begin
          r.read_data = '0;
          r.bus_claimed = 1'b1;
          r.rom_read = 1'b1;
          r.rom_address = {9'd0, a.offset} | cird_pkg::ROM_WINDOW_BASE | {bank_q, 14'd0};
        end else if (a.offset >= cird_pkg::OFF_ATA_LO && a.offset <= cird_pkg::OFF_ATA_HI) begin
          rd_latch = a.ata_read_data;
          r.ata_action = cird_pkg::ATA_READ;
          r.ata_register = a.offset[3:0];
          if (layout_v4) begin
            r.read_data = rd_latch[7:0];
            r.bus_claimed = 1'b1;
          end
        end else if (a.offset == cird_pkg::OFF_DATA_LO && !layout_v4) begin
          r.read_data = rd_latch[7:0];
          r.bus_claimed = 1'b1;
        end else if (a.offset == cird_pkg::OFF_DATA_HI) begin
          r.read_data = rd_latch[15:8];
          r.bus_claimed = 1'b1;
        end else if (a.offset == cird_pkg::OFF_STATUS) begin
          d = layout_v4 ? cird_pkg::STATUS_NEW_TAG : cird_pkg::STATUS_OLD_TAG;
          r.read_data = d | {3'd0, bank_q, 2'd0} | {6'd0, ~mode_q[0], mode_q[1]};
          r.bus_claimed = 1'b1;
        end else if (a.offset == cird_pkg::OFF_ID && layout_v4) begin
          r.read_data = cird_pkg::ID_BYTE;
          r.bus_claimed = 1'b1;
        end else if (a.offset == cird_pkg::OFF_STATUS2 && layout_v4) begin
          r.read_data = cird_pkg::STATUS2_MASK | a.open_bus_data;
          r.bus_claimed = 1'b1;
        end else if (a.offset == cird_pkg::OFF_RTC) begin
          r.bus_claimed = 1'b1;
          if (kill_q[cird_pkg::CLOCK_BIT]) begin
            r.read_data[0] = a.rtc_data_in;
            r.rtc_action = cird_pkg::RTC_READ_BIT;
          end
        end
      end
    end else if (!killed) begin
      if (a.offset >= cird_pkg::OFF_ATA_LO && a.offset <= cird_pkg::OFF_ATA_HI) begin
        if (a.offset == cird_pkg::OFF_PAIR_LO || a.offset == cird_pkg::OFF_PAIR_HI)
          pair_q = a.offset[0];
        if (layout_v4) wr_latch[7:0] = a.write_data;
        r.ata_action = cird_pkg::ATA_WRITE;
        r.ata_register = a.offset[3:0];
        r.ata_write_data = wr_latch;
      end else if (a.offset == cird_pkg::OFF_DATA_LO) begin
        if (!layout_v4) wr_latch[7:0] = a.write_data;
      end else if (a.offset == cird_pkg::OFF_DATA_HI) begin
        wr_latch[15:8] = a.write_data;
      end else if (a.offset >= cird_pkg::OFF_STATUS && a.offset <= cird_pkg::OFF_BANK_OLD_HI) begin
        // Old layout bank select; the map refreshes in either layout.
        if (!layout_v4) begin
          b = a.offset[1:0] - 2'd2;
          bank_q = {1'b0, b};
        end
        r.map_update = 1'b1;
      end else if (a.offset == cird_pkg::OFF_RTC) begin
        if (kill_q[cird_pkg::CLOCK_BIT]) r.rtc_action = cird_pkg::RTC_WRITE_BIT;
        else r.map_update = 1'b1;
      end else if (a.offset >= cird_pkg::OFF_ROM_LO
                   && a.offset <= cird_pkg::OFF_BANK_NEW_HI) begin
        if (layout_v4) bank_q = a.offset[2:0];
        r.map_update = 1'b1;
      end else if (a.offset == cird_pkg::OFF_KILL) begin
        // A rising clock enable drops the chip enable line first.
        if (!kill_q[cird_pkg::CLOCK_BIT] && a.write_data[cird_pkg::CLOCK_BIT])
          r.rtc_action = cird_pkg::RTC_CE_DROP;
        kill_q = a.write_data;
        if (kill_q[cird_pkg::KILL_BIT]) begin
          mode_q = cird_pkg::MODE_STD;
          r.map_update = 1'b1;
        end
      end else if (a.offset >= cird_pkg::OFF_MODE_LO) begin
        mode_q = {a.offset[1], ~a.offset[0]};
        r.map_update = 1'b1;
      end
    end
    r.drive_pair = pair_q;
    r.map_mode = cird_pkg::map_mode_e'(mode_q);
    r.map_bank = bank_q;
    return r;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [16:0] got, logic [16:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got 0x%0h, want 0x%0h",
                                results_seen, name, got, want));
  endtask

  task automatic check_result(cird_pkg::out_beat_t got, cird_pkg::out_beat_t want);
    check_field("read_data", 17'(got.read_data), 17'(want.read_data));
    check_field("bus_claimed", 17'(got.bus_claimed), 17'(want.bus_claimed));
    check_field("rom_read", 17'(got.rom_read), 17'(want.rom_read));
    check_field("rom_address", got.rom_address, want.rom_address);
    check_field("ata_action", 17'(got.ata_action), 17'(want.ata_action));
    check_field("ata_register", 17'(got.ata_register), 17'(want.ata_register));
    check_field("ata_write_data", 17'(got.ata_write_data), 17'(want.ata_write_data));
    check_field("drive_pair", 17'(got.drive_pair), 17'(want.drive_pair));
    check_field("rtc_action", 17'(got.rtc_action), 17'(want.rtc_action));
    check_field("map_update", 17'(got.map_update), 17'(want.map_update));
    check_field("map_mode", 17'(got.map_mode), 17'(want.map_mode));
    check_field("map_bank", 17'(got.map_bank), 17'(want.map_bank));
  endtask

  // Sample both channels at the rising edge: predict accepted beats, check results.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      cird_pkg::out_beat_t p;
      p = decode_access(in_data);
      predicted_results.push_back(p);
      accesses_taken++;
      if (in_data.kind == cird_pkg::KIND_WRITE) writes_taken++;
      if (p.rom_read) rom_reads++;
      if (p.ata_action != cird_pkg::ATA_NONE) ata_ops++;
      if (p.rtc_action != cird_pkg::RTC_NONE) rtc_ops++;
      if (p.map_update) map_updates++;
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (predicted_results.size() == 0)
        report_mismatch($sformatf("result %0d arrived with no access outstanding",
                                  results_seen));
      else
        check_result(out_data, predicted_results.pop_front());
    end
  end

  // Sender: offer the next queued access at the falling edge once the last one is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_accesses.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_accesses.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus the long hold-off window.
  always @(negedge clk) begin
    out_ready <= !hold_off && ($urandom_range(0, 99) >= idle_pct);
  end

  // Long receiver hold-off in the middle of the run so the decoder backs up.
  initial begin
    wait (accesses_taken >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (80) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Run limit.
  initial begin
    #400000;
    $display("cartridge_io_register_decoder test failed");
    $finish;
  end

  task automatic queue_access(logic k, logic [7:0] off, logic [7:0] wd,
                              logic [15:0] ata, logic rtc, logic [7:0] ob);
    cird_pkg::in_beat_t a;
    a.kind = k;
    a.offset = off;
    a.write_data = wd;
    a.ata_read_data = ata;
    a.rtc_data_in = rtc;
    a.open_bus_data = ob;
    pending_accesses.push_back(a);
  endtask

  // Random accesses, weighted toward mapped registers so latch and bank sequences form.
  task automatic queue_random(int n, logic allow_kill);
    cird_pkg::in_beat_t a;
    for (int i = 0; i < n; i++) begin
      a.kind = 1'($urandom_range(0, 1));
      a.write_data = 8'($urandom);
      a.ata_read_data = 16'($urandom);
      a.rtc_data_in = 1'($urandom);
      a.open_bus_data = 8'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2: a.offset = 8'(cird_pkg::OFF_ATA_LO + $urandom_range(0, 15));
        3:       a.offset = 8'(cird_pkg::OFF_DATA_LO + $urandom_range(0, 1));
        4:       a.offset = 8'(cird_pkg::OFF_STATUS + $urandom_range(0, 3));
        5:       a.offset = 8'(cird_pkg::OFF_ID + $urandom_range(0, 2));
        6:       a.offset = 8'(cird_pkg::OFF_ROM_LO + $urandom_range(0, 7));
        7:       a.offset = 8'(cird_pkg::OFF_KILL + $urandom_range(0, 4));
        default: a.offset = 8'($urandom_range(0, 255));
      endcase
      // The kill bit can only be cleared by reset, so hold it back until the end.
      if (!allow_kill && a.kind == cird_pkg::KIND_WRITE && a.offset == cird_pkg::OFF_KILL)
        a.write_data[cird_pkg::KILL_BIT] = 1'b0;
      pending_accesses.push_back(a);
    end
  endtask

  // Wait until every queued access is taken and every result has come back.
  task automatic wait_idle();
    int n;
    n = 0;
    while (!(pending_accesses.size() == 0 && !in_valid && predicted_results.size() == 0)
           && n < 20000) begin
      @(negedge clk);
      n++;
    end
    if (predicted_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", predicted_results.size()));
    repeat (4) @(negedge clk);
  endtask

  task automatic write_layout(logic v4);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v4;
    @(negedge clk);
    cfg_we <= 1'b0;
    layout_v4 = v4;
  endtask

  // Main sequence: reset, directed accesses in each layout, random traffic, kill at the end.
  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Old layout: clock chip, data latches, pair select, bank, mode and unmapped offsets.
    write_layout(1'b0);
    queue_access(cird_pkg::KIND_WRITE, cird_pkg::OFF_KILL, 8'h02, 16'h0000, 1'b0, 8'h00);
    queue_access(cird_pkg::KIND_READ, cird_pkg::OFF_RTC, 8'h00, 16'h0000, 1'b1, 8'h00);
    queue_access(cird_pkg::KIND_WRITE, cird_pkg::OFF_RTC, 8'h01, 16'h0000, 1'b0, 8'h00);
    queue_access(cird_pkg::KIND_WRITE, cird_pkg::OFF_DATA_LO, 8'ha5, 16'h0000, 1'b0, 8'h00);
    queue_access(cird_pkg::KIND_WRITE, cird_pkg::OFF_DATA_HI, 8'h5a, 16'h0000, 1'b0, 8'h00);
    queue_access(cird_pkg::KIND_WRITE, cird_pkg::OFF_PAIR_HI, 8'hff, 16'h0000, 1'b0, 8'h00);
    queue_access(cird_pkg::KIND_READ, cird_pkg::OFF_ATA_HI, 8'h00, 16'hffff, 1'b0, 8'h00);
    queue_access(cird_pkg::KIND_READ, cird_pkg::OFF_DATA_LO, 8'h00, 16'h0000, 1'b0, 8'h00);
    queue_access(cird_pkg::KIND_WRITE, cird_pkg::OFF_BANK_OLD_HI, 8'h00, 16'h0000, 1'b0,
                 8'h00);
    queue_access(cird_pkg::KIND_READ, cird_pkg::OFF_STATUS, 8'h00, 16'h0000, 1'b0, 8'h00);
    queue_access(cird_pkg::KIND_READ, 8'hff, 8'h00, 16'h0000, 1'b0, 8'hff);
    queue_access(cird_pkg::KIND_WRITE, 8'hff, 8'h00, 16'h0000, 1'b0, 8'h00);
    queue_access(cird_pkg::KIND_READ, 8'h00, 8'h00, 16'h0000, 1'b0, 8'haa);
    queue_access(cird_pkg::KIND_WRITE, 8'h00, 8'hff, 16'h0000, 1'b0, 8'h00);
    queue_access(cird_pkg::KIND_WRITE, cird_pkg::OFF_ROM_LO, 8'h00, 16'h0000, 1'b0, 8'h00);
    queue_access(cird_pkg::KIND_WRITE, cird_pkg::OFF_KILL, 8'h00, 16'h0000, 1'b0, 8'h00);
    queue_access(cird_pkg::KIND_READ, cird_pkg::OFF_RTC, 8'h00, 16'h0000, 1'b1, 8'h5b);
    queue_access(cird_pkg::KIND_WRITE, cird_pkg::OFF_RTC, 8'h01, 16'h0000, 1'b0, 8'h00);
    wait_idle();

    // New layout: id and status bytes, bank select, byte-wide drive data, then random traffic; no idling here.
    write_layout(1'b1);
    idle_pct = 0;
    queue_access(cird_pkg::KIND_READ, cird_pkg::OFF_ID, 8'h00, 16'h0000, 1'b0, 8'h00);
    queue_access(cird_pkg::KIND_READ, cird_pkg::OFF_STATUS2, 8'h00, 16'h0000, 1'b0, 8'h3c);
    queue_access(cird_pkg::KIND_WRITE, cird_pkg::OFF_BANK_NEW_HI, 8'h00, 16'h0000, 1'b0,
                 8'h00);
    queue_access(cird_pkg::KIND_READ, cird_pkg::OFF_ROM_LO, 8'h00, 16'h0000, 1'b0, 8'h00);
    queue_access(cird_pkg::KIND_READ, 8'h2a, 8'h00, 16'h1234, 1'b0, 8'h00);
    queue_random(220, 1'b0);
    wait_idle();

    // Old layout with random idling; the receiver hold-off lands in this stretch.
    idle_pct = 27;
    write_layout(1'b0);
    queue_random(220, 1'b0);
    wait_idle();

    write_layout(1'b1);
    queue_random(200, 1'b0);
    wait_idle();

    // Killed cartridge: upper offsets go dead, lower registers still answer.
    queue_access(cird_pkg::KIND_WRITE, cird_pkg::OFF_KILL, 8'h03, 16'h0000, 1'b0, 8'h00);
    queue_access(cird_pkg::KIND_READ, cird_pkg::OFF_RTC, 8'h00, 16'h0000, 1'b1, 8'h81);
    queue_access(cird_pkg::KIND_WRITE, cird_pkg::OFF_KILL, 8'h00, 16'h0000, 1'b0, 8'h00);
    queue_access(cird_pkg::KIND_READ, cird_pkg::OFF_STATUS, 8'h00, 16'h0000, 1'b0, 8'h00);
    queue_random(80, 1'b1);
    wait_idle();

    $display("Checked %0d accesses (%0d writes) in both layouts and the killed state.",
             accesses_taken, writes_taken);
    $display("Seen: %0d ROM reads, %0d drive accesses, %0d clock pulses, %0d map refreshes.",
             rom_reads, ata_ops, rtc_ops, map_updates);
    if (mismatches == 0) begin
      $display("cartridge_io_register_decoder test passed");
    end else begin
      $display("cartridge_io_register_decoder test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
